FILE: sv/pat_pkg.sv
package pat_pkg;

    // Table geometry.
    localparam int MAX_ENTRIES = 16;
    localparam int SLOT_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W      = 32;
    localparam int CFG_W       = 5;
    localparam int CMP_W       = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    localparam logic [CFG_W-1:0] CFG_LIMIT_RESET = CFG_W'(10);

    // Action codes.
    localparam logic [2:0] ACT_ADD      = 3'd0;
    localparam logic [2:0] ACT_REMOVE   = 3'd1;
    localparam logic [2:0] ACT_SET_ACK  = 3'd2;
    localparam logic [2:0] ACT_CLR_ACK  = 3'd3;
    localparam logic [2:0] ACT_CLR_ALL  = 3'd4;
    localparam logic [2:0] ACT_LIST     = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [2:0]        action;
        logic [ADDR_W-1:0] peer_address;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              all_acked;
        logic [CNT_W-1:0]  peer_count;
        logic [ADDR_W-1:0] listed_address;
        logic              listed_valid;
        logic              last;
    } rsp_t;

    // One result beat from the sequencer to the output register.
    typedef struct packed {
        logic load;
        rsp_t data;
    } rsp_beat_t;

endpackage

FILE: sv/pat_ram.sv
module pat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/pat_ctrl.sv
module pat_ctrl
    import pat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start_acc,
    input  cmd_t             cmd,
    input  logic [CNT_W-1:0] limit,
    output logic             busy,
    output rsp_beat_t        beat
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_FETCH  = 5'b00100,
        S_MOVE   = 5'b01000,
        S_LIST   = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [2:0]             act_reg, act_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [CNT_W-1:0]       scan_reg, scan_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]      cmp_slot_reg, cmp_slot_next;
    logic [SLOT_W-1:0]      hit_slot_reg, hit_slot_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [MAX_ENTRIES-1:0] ack_reg, ack_next;

    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [ADDR_W-1:0] wr_data;
    logic [SLOT_W-1:0] rd_addr;
    logic [ADDR_W-1:0] rd_data;

    logic [2:0]             act_cur;
    logic [ADDR_W-1:0]      addr_cur;
    logic [CNT_W-1:0]       count_dec;
    logic [SLOT_W-1:0]      last_slot;
    logic [MAX_ENTRIES-1:0] live_mask;
    logic [MAX_ENTRIES-1:0] later_mask;
    logic [MAX_ENTRIES-1:0] unacked;
    logic [MAX_ENTRIES-1:0] live_next;

    logic              hit, miss;
    logic [SLOT_W-1:0] hit_slot;
    logic              emit;
    logic [1:0]        emit_status;
    logic [ADDR_W-1:0] emit_addr;
    logic              emit_valid;
    logic              emit_last;

    // Address store for the peers.
    pat_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The command is taken straight from the port in the accept cycle.
    assign act_cur   = (state_reg == S_IDLE) ? cmd.action : act_reg;
    assign addr_cur  = (state_reg == S_IDLE) ? cmd.peer_address : addr_reg;
    assign count_dec = count_reg - CNT_W'(1);
    assign last_slot = count_dec[SLOT_W-1:0];

    // Occupied slots, and slots beyond the one being compared.
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            live_mask[i]  = (CNT_W'(i) < count_reg);
            later_mask[i] = (CNT_W'(i) > CNT_W'(cmp_slot_reg));
        end
    end

    // Slots occupied once the current action has been applied.
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            live_next[i] = (CNT_W'(i) < count_next);
        end
    end

    assign unacked = ~ack_reg & live_mask;

    // Sequencer: the search, the move on remove and the list walk share
    // one read port; only the search uses the address comparator.
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        addr_next      = addr_reg;
        scan_next      = scan_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_slot_next  = cmp_slot_reg;
        hit_slot_next  = hit_slot_reg;
        count_next     = count_reg;
        ack_next       = ack_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[SLOT_W-1:0];
        wr_data        = addr_cur;
        rd_addr        = scan_reg[SLOT_W-1:0];
        hit            = 1'b0;
        miss           = 1'b0;
        hit_slot       = cmp_slot_reg;
        emit           = 1'b0;
        emit_status    = ST_DONE;
        emit_addr      = '0;
        emit_valid     = 1'b0;
        emit_last      = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start_acc)
                begin
                    act_next       = cmd.action;
                    addr_next      = cmd.peer_address;
                    scan_next      = '0;
                    cmp_valid_next = 1'b0;
                    priority case (cmd.action)
                        ACT_ADD, ACT_REMOVE, ACT_SET_ACK, ACT_CLR_ACK:
                        begin
                            if (cmd.action == ACT_ADD && count_reg >= limit)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                miss = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        ACT_CLR_ALL:
                        begin
                            ack_next = '0;
                            emit     = 1'b1;
                        end
                        ACT_LIST:
                        begin
                            if (unacked == '0)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                // Issue the next slot while the previous one is compared.
                if (scan_reg < count_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_slot_next  = scan_reg[SLOT_W-1:0];
                    scan_next      = scan_reg + CNT_W'(1);
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
                if (cmp_valid_reg)
                begin
                    if (rd_data == addr_reg)
                    begin
                        hit = 1'b1;
                    end
                    else if (CNT_W'(cmp_slot_reg) == count_dec)
                    begin
                        miss = 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                rd_addr    = last_slot;
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                // The last entry fills the freed slot.
                wr_en                   = 1'b1;
                wr_addr                 = hit_slot_reg;
                wr_data                 = rd_data;
                ack_next[hit_slot_reg]  = ack_reg[last_slot];
                ack_next[last_slot]     = 1'b0;
                count_next              = count_dec;
                emit                    = 1'b1;
                state_next              = S_IDLE;
            end
            S_LIST:
            begin
                if (scan_reg < count_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_slot_next  = scan_reg[SLOT_W-1:0];
                    scan_next      = scan_reg + CNT_W'(1);
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
                if (cmp_valid_reg && !ack_reg[cmp_slot_reg])
                begin
                    emit       = 1'b1;
                    emit_addr  = rd_data;
                    emit_valid = 1'b1;
                    emit_last  = ((unacked & later_mask) == '0);
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Outcome of a search, shared by the idle and search states.
        if (hit)
        begin
            priority case (act_cur)
                ACT_SET_ACK:
                begin
                    ack_next[hit_slot] = 1'b1;
                    emit               = 1'b1;
                    state_next         = S_IDLE;
                end
                ACT_CLR_ACK:
                begin
                    ack_next[hit_slot] = 1'b0;
                    emit               = 1'b1;
                    state_next         = S_IDLE;
                end
                ACT_REMOVE:
                begin
                    hit_slot_next = hit_slot;
                    state_next    = S_FETCH;
                end
                default:
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            endcase
        end
        else if (miss)
        begin
            if (act_cur == ACT_ADD)
            begin
                // Append in the next free slot with the bit set.
                wr_en                              = 1'b1;
                wr_addr                            = count_reg[SLOT_W-1:0];
                wr_data                            = addr_cur;
                ack_next[count_reg[SLOT_W-1:0]]    = 1'b1;
                count_next                         = count_reg + CNT_W'(1);
                emit                               = 1'b1;
            end
            else
            begin
                emit        = 1'b1;
                emit_status = ST_NOT_FOUND;
            end
            state_next = S_IDLE;
        end
    end

    // Result beat, reporting the table as it stands after the action.
    always_comb
    begin
        beat.load                = emit;
        beat.data.status         = emit_status;
        beat.data.all_acked      = ((~ack_next & live_next) == '0);
        beat.data.peer_count     = count_next;
        beat.data.listed_address = emit_addr;
        beat.data.listed_valid   = emit_valid;
        beat.data.last           = emit_last;
    end

    assign busy = (state_reg != S_IDLE);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmp_valid_reg <= 1'b0;
            count_reg     <= '0;
            ack_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            count_reg     <= count_next;
            ack_reg       <= ack_next;
        end
    end

    // Working registers of the current command.
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        addr_reg     <= addr_next;
        scan_reg     <= scan_next;
        cmp_slot_reg <= cmp_slot_next;
        hit_slot_reg <= hit_slot_next;
    end

endmodule

FILE: sv/peer_ack_tracking_table_top.sv
// Channel   Direction  Handshake                  Beat
// command   in         start high, busy low       cmd (action, peer_address)
// result    out        done strobe, one cycle     rsp (status .. last)
// config    in         cfg_valid and cfg_ready    cfg_data (peer limit)
//
// Add, remove, set ack and clear ack walk the occupied slots through the single
// read port of the address store, and a remove then moves the last entry into the
// freed slot. Clear all, an empty table, a full add and an undefined action answer at once.
// A list gives one beat per unacknowledged peer, or a single beat when there is none.
// Results appear in the cycle after they are formed; the receiver cannot stall.
// Reset clears the count and the acknowledge bits; the address store is not cleared.
module peer_ack_tracking_table_top
    import pat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    output logic             done,
    output rsp_t             rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0] cfg_limit_reg;
    logic [CMP_W-1:0] max_wide;
    logic [CNT_W-1:0] limit;
    rsp_beat_t        beat;
    logic             done_reg;
    rsp_t             rsp_reg;

    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_limit_reg <= CFG_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_limit_reg <= cfg_data;
        end
    end

    // The limit is held between one and the table depth.
    assign max_wide = CMP_W'(cfg_limit_reg);
    always_comb
    begin
        priority if (max_wide == '0)
        begin
            limit = CNT_W'(1);
        end
        else if (max_wide > CMP_W'(MAX_ENTRIES))
        begin
            limit = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            limit = CNT_W'(max_wide);
        end
    end

    pat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start_acc (start && !busy),
        .cmd       (cmd),
        .limit     (limit),
        .busy      (busy),
        .beat      (beat)
    );

    // Output register: each result is shown for one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= beat.load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat.load)
        begin
            rsp_reg <= beat.data;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    import pat_pkg::*;

    // Action codes the block leaves undefined; it must answer them and change nothing.
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    localparam int POOL_SIZE      = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 40;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    cmd_t             cmd       = '0;
    logic             done;
    rsp_t             rsp;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;

    // Commands waiting for the driver, and replies the table should give.
    cmd_t        pending_cmds[$];
    rsp_t        expected_replies[$];
    int          cmds_queued = 0;
    int          cmds_taken  = 0;
    int          idle_left   = 0;
    int          quiet_cycles = 0;
    int          errors      = 0;
    logic        no_gaps     = 1'b0;
    logic [31:0] addr_pool [POOL_SIZE];

    // Shadow copy of the peer table and its limit register.
    logic [31:0]      tbl_addr [MAX_ENTRIES];
    logic [15:0]      tbl_ack     = '0;
    int               tbl_count   = 0;
    logic [CFG_W-1:0] shadow_limit = CFG_LIMIT_RESET;

    peer_ack_tracking_table_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The register value is clamped to 1..MAX_ENTRIES before use.
    function automatic int peer_limit();
        int m;
        m = int'(shadow_limit);
        if (m < 1) m = 1;
        if (m > MAX_ENTRIES) m = MAX_ENTRIES;
        return m;
    endfunction

    function automatic int find_peer(input logic [31:0] a);
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_addr[i] == a) return i;
        end
        return -1;
    endfunction

    function automatic logic table_all_acked();
        logic [15:0] m;
        m = (tbl_count >= 16) ? 16'hFFFF : 16'((32'd1 << tbl_count) - 1);
        return (tbl_count == 0) || ((tbl_ack & m) == m);
    endfunction

    function automatic void push_reply(input logic [1:0] st, input logic [31:0] a,
                                       input logic v, input logic l);
        rsp_t r;
        r.status         = st;
        r.all_acked      = table_all_acked();
        r.peer_count     = CNT_W'(tbl_count);
        r.listed_address = a;
        r.listed_valid   = v;
        r.last           = l;
        expected_replies = {expected_replies, r};
    endfunction

    // Applies one accepted command to the shadow table and queues its replies.
    function automatic void update_table(input cmd_t c);
        logic [1:0]  st;
        logic [31:0] a;
        int          idx;
        int          tail;
        int          unacked;
        int          seen;
        st = ST_DONE;
        a  = c.peer_address;
        case (c.action)
            ACT_ADD:
            begin
                // The full test comes first, even for an address already present.
                if (tbl_count >= peer_limit())
                    st = ST_FULL;
                else if (find_peer(a) < 0)
                begin
                    tbl_addr[tbl_count] = a;
                    tbl_ack[tbl_count]  = 1'b1;
                    tbl_count++;
                end
            end
            ACT_REMOVE:
            begin
                idx = find_peer(a);
                if (idx < 0)
                    st = ST_NOT_FOUND;
                else
                begin
                    // The last entry fills the hole so that the table stays dense.
                    tail = tbl_count - 1;
                    if (idx != tail)
                    begin
                        tbl_addr[idx] = tbl_addr[tail];
                        tbl_ack[idx]  = tbl_ack[tail];
                    end
                    tbl_ack[tail] = 1'b0;
                    tbl_count     = tail;
                end
            end
            ACT_SET_ACK, ACT_CLR_ACK:
            begin
                idx = find_peer(a);
                if (idx < 0)
                    st = ST_NOT_FOUND;
                else
                    tbl_ack[idx] = (c.action == ACT_SET_ACK);
            end
            ACT_CLR_ALL:
                tbl_ack = '0;
            ACT_LIST:
            begin
                unacked = 0;
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (!tbl_ack[i]) unacked++;
                end
                if (unacked == 0)
                    push_reply(ST_DONE, 32'h0, 1'b0, 1'b1);
                seen = 0;
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (!tbl_ack[i])
                    begin
                        seen++;
                        push_reply(ST_DONE, tbl_addr[i], 1'b1, seen == unacked);
                    end
                end
                return;
            end
            default:
            begin
            end
        endcase
        push_reply(st, 32'h0, 1'b0, 1'b1);
    endfunction

    // Command driver: holds a beat until it is taken, with random gaps between beats.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                update_table(cmd);
                cmds_taken++;
            end
            if (!start || !busy)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0 && !no_gaps && $urandom_range(0, 5) == 0)
                begin
                    idle_left = $urandom_range(0, 7);
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    start <= 1'b1;
                    cmd   <= pending_cmds.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Reply monitor and watchdog.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
            else if (done)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("reply beat with none expected: %p", rsp);
                    errors++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.all_acked !== want.all_acked)
                    begin
                        $error("all_acked: expected %0b, got %0b", want.all_acked,
                               rsp.all_acked);
                        errors++;
                    end
                    if (rsp.peer_count !== want.peer_count)
                    begin
                        $error("peer_count: expected %0d, got %0d", want.peer_count,
                               rsp.peer_count);
                        errors++;
                    end
                    if (rsp.listed_address !== want.listed_address)
                    begin
                        $error("listed_address: expected %h, got %h", want.listed_address,
                               rsp.listed_address);
                        errors++;
                    end
                    if (rsp.listed_valid !== want.listed_valid)
                    begin
                        $error("listed_valid: expected %0b, got %0b", want.listed_valid,
                               rsp.listed_valid);
                        errors++;
                    end
                    if (rsp.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, rsp.last);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic send(input logic [2:0] act, input logic [31:0] a);
        cmd_t c;
        c.action       = act;
        c.peer_address = a;
        pending_cmds   = {pending_cmds, c};
        cmds_queued++;
    endtask

    // Waits until every queued command has been taken and fully answered.
    task automatic drain();
        while (cmds_taken != cmds_queued || expected_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        shadow_limit = v;
    endtask

    // Mostly addresses from a small pool so that peers are found, with some noise.
    task automatic random_phase(input int n);
        int          r;
        logic [2:0]  act;
        logic [31:0] a;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 38)      act = ACT_ADD;
            else if (r < 53) act = ACT_REMOVE;
            else if (r < 66) act = ACT_SET_ACK;
            else if (r < 78) act = ACT_CLR_ACK;
            else if (r < 82) act = ACT_CLR_ALL;
            else if (r < 96) act = ACT_LIST;
            else             act = ($urandom_range(0, 1) == 0) ? ACT_SPARE_6 : ACT_SPARE_7;
            if ($urandom_range(0, 99) < 85)
                a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                a = $urandom();
            send(act, a);
        end
        drain();
    endtask

    initial
    begin
        for (int p = 0; p < POOL_SIZE; p++)
            addr_pool[p] = $urandom();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table, extreme addresses, present and unknown peers, slot moves.
        send(ACT_LIST,    32'h0000_0000);
        send(ACT_REMOVE,  32'h0000_0000);
        send(ACT_SET_ACK, 32'hFFFF_FFFF);
        send(ACT_ADD,     32'h0000_0000);
        send(ACT_ADD,     32'hFFFF_FFFF);
        send(ACT_ADD,     32'h1234_5678);
        send(ACT_ADD,     32'h0000_0000);
        send(ACT_CLR_ACK, 32'hFFFF_FFFF);
        send(ACT_CLR_ACK, 32'h0000_0000);
        send(ACT_LIST,    32'hFFFF_FFFF);
        send(ACT_CLR_ACK, 32'hDEAD_BEEF);
        send(ACT_SET_ACK, 32'h0000_0000);
        send(ACT_REMOVE,  32'h0000_0000);
        send(ACT_LIST,    32'h0000_0000);
        send(ACT_CLR_ALL, 32'hFFFF_FFFF);
        send(ACT_LIST,    32'h0000_0000);
        send(ACT_REMOVE,  32'hFFFF_FFFF);
        send(ACT_SPARE_6, 32'h1234_5678);
        send(ACT_SPARE_7, 32'hFFFF_FFFF);
        drain();

        // A limit at or below the count makes every add report full.
        write_limit(5'd1);
        send(ACT_ADD,  32'h1234_5678);
        send(ACT_ADD,  32'h0F0F_0F0F);
        send(ACT_LIST, 32'h0000_0000);
        drain();
        write_limit(5'd0);
        send(ACT_ADD,    32'hF0F0_F0F0);
        send(ACT_REMOVE, 32'h1234_5678);
        send(ACT_ADD,    32'hA5A5_A5A5);
        send(ACT_LIST,   32'h0000_0000);
        drain();

        // Random traffic under several limits, the last part without gaps.
        write_limit(5'd31);
        random_phase(70);
        write_limit(5'd16);
        random_phase(70);
        write_limit(5'd4);
        random_phase(70);
        write_limit(5'd2);
        random_phase(70);
        write_limit(5'd13);
        no_gaps = 1'b1;
        random_phase(70);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_replies.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
